>>> src/pvolf_pkg.sv
// ----------------------------------------------------------------------------
// pvolf_pkg
// Shared types and constants for the per-value occurrence limit filter.
// ----------------------------------------------------------------------------
package pvolf_pkg;

   localparam int unsigned DEFAULT_TABLE_ENTRIES = 1024;

   localparam int unsigned KEY_W   = 64;
   localparam int unsigned COUNT_W = 32;

   localparam logic [KEY_W-1:0]   HASH_MULT   = 64'h9E3779B97F4A7C15;
   localparam logic [COUNT_W-1:0] COUNT_MAX   = 32'hFFFF_FFFF;
   localparam logic [COUNT_W-1:0] LIMIT_RESET = 32'd1;

   // Configuration port: one 32-bit register at byte address 0.
   localparam int unsigned CSR_ADDR_W    = 3;
   localparam int unsigned CSR_DATA_W    = 32;
   localparam logic        CSR_IDX_LIMIT = 1'b0;

   typedef struct packed {
      logic signed [KEY_W-1:0] value;
      logic                    is_null;
   } req_type;

   typedef struct packed {
      logic pass;
      logic table_full_error;
   } rsp_type;

   // One table slot: valid flag, stored key and occurrence count.
   typedef struct packed {
      logic               valid;
      logic [KEY_W-1:0]   key;
      logic [COUNT_W-1:0] count;
   } entry_type;

endpackage

>>> src/pvolf_ram.sv
// ----------------------------------------------------------------------------
// pvolf_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module pvolf_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> src/per_value_occurrence_limit_filter.sv
// ----------------------------------------------------------------------------
// per_value_occurrence_limit_filter
// Counts occurrences of each distinct 64-bit value in a hashed table with
// linear probing and passes an item while its count is within the limit.
// ----------------------------------------------------------------------------
//  channel   ports                          handshake
//  request   start, busy, req_data          taken when start && !busy
//  result    rsp_valid, rsp_data            one-cycle strobe, no back-pressure
//  config    psel, penable, pwrite, paddr,  write on psel&penable&pwrite,
//            pwdata, prdata, pready         pready tied high
//
//  A null request gives its result the next cycle and busy stays low.
//  Otherwise busy is high while the key is hashed, 1..TABLE_ENTRIES slots are
//  probed one per cycle through the table RAM read port and the slot is
//  written; a table-full request probes every slot and writes none. A table
//  size that is not a power of two adds a remainder step: four 16-bit digits,
//  each a reciprocal multiply, a back-multiply and one correcting subtract.
//  The hash and the remainder share one 32x32 multiplier. After reset the
//  table is cleared one slot a cycle with busy high. Results cannot be stalled.
// ----------------------------------------------------------------------------
module per_value_occurrence_limit_filter #(
   parameter int unsigned TABLE_ENTRIES = pvolf_pkg::DEFAULT_TABLE_ENTRIES
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  pvolf_pkg::req_type                  req_data,
   output logic                                rsp_valid,
   output pvolf_pkg::rsp_type                  rsp_data,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [pvolf_pkg::CSR_ADDR_W-1:0]    paddr,
   input  logic [pvolf_pkg::CSR_DATA_W-1:0]    pwdata,
   output logic [pvolf_pkg::CSR_DATA_W-1:0]    prdata,
   output logic                                pready
);

   import pvolf_pkg::*;

   localparam int unsigned IDX_W   = $clog2(TABLE_ENTRIES);
   localparam bit          IS_POW2 = (TABLE_ENTRIES == (1 << IDX_W));
   localparam logic [IDX_W-1:0] LAST_SLOT  = IDX_W'(TABLE_ENTRIES - 1);
   localparam logic [31:0]      ENTRIES_32 = 32'(TABLE_ENTRIES);
   // floor(2^32 / TABLE_ENTRIES)
   localparam logic [31:0]      RECIP      = 32'(64'h1_0000_0000 / 64'(TABLE_ENTRIES));
   localparam logic [1:0]       DIGIT_LAST = 2'd3;

   typedef enum logic [11:0] {
      ST_CLEAR    = 12'b0000_0000_0001,
      ST_IDLE     = 12'b0000_0000_0010,
      ST_MUL0     = 12'b0000_0000_0100,
      ST_MUL1     = 12'b0000_0000_1000,
      ST_MUL2     = 12'b0000_0001_0000,
      ST_MUL3     = 12'b0000_0010_0000,
      ST_MIX      = 12'b0000_0100_0000,
      ST_MOD_EST  = 12'b0000_1000_0000,
      ST_MOD_BACK = 12'b0001_0000_0000,
      ST_MOD_FIX  = 12'b0010_0000_0000,
      ST_PROBE    = 12'b0100_0000_0000,
      ST_UPDATE   = 12'b1000_0000_0000
   } state_type;

   state_type          state_ff, state_in;
   logic [IDX_W-1:0]   slot_ff, slot_in;
   logic [IDX_W-1:0]   probe_ff, probe_in;
   logic [KEY_W-1:0]   key_ff, key_in;
   logic [KEY_W-1:0]   acc_ff, acc_in;
   logic [KEY_W-1:0]   mul_ff, mul_in;
   logic [IDX_W-1:0]   rem_ff, rem_in;
   logic [1:0]         bit_ff, bit_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [COUNT_W-1:0] limit_ff, limit_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_ff, rsp_in;

   logic [31:0]        mul_a, mul_b;
   logic [KEY_W-1:0]   mixed;
   logic [31:0]        mod_y;
   logic [31:0]        mod_diff;
   logic [IDX_W-1:0]   rem_next;
   logic [IDX_W-1:0]   slot_step;
   logic [COUNT_W-1:0] count_next;
   logic               wr_en;
   logic [IDX_W-1:0]   wr_addr;
   entry_type          wr_entry;
   entry_type          rd_entry;
   logic               csr_write;
   logic               csr_sel_limit;

   pvolf_ram #(
      .WIDTH ($bits(entry_type)),
      .DEPTH (TABLE_ENTRIES)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_entry),
      .rd_addr (slot_in),
      .rd_data (rd_entry)
   );

   assign csr_sel_limit = (paddr[CSR_ADDR_W-1:2] == CSR_IDX_LIMIT);
   assign csr_write     = psel && penable && pwrite && csr_sel_limit;
   assign pready        = 1'b1;
   assign prdata        = csr_sel_limit ? limit_ff : '0;

   assign mixed      = acc_ff ^ (acc_ff >> 29);
   // partial remainder followed by the next 16-bit digit, MSB first
   assign mod_y      = {16'(rem_ff), acc_ff[KEY_W-1 -: 16]};
   assign mod_diff   = mod_y - mul_ff[31:0];
   assign rem_next   = (mod_diff >= ENTRIES_32) ? IDX_W'(mod_diff - ENTRIES_32)
                                                : mod_diff[IDX_W-1:0];
   assign slot_step  = (slot_ff == LAST_SLOT) ? '0 : slot_ff + 1'b1;
   assign count_next = (count_ff == COUNT_MAX) ? count_ff : count_ff + 1'b1;

   always_comb begin
      state_in     = state_ff;
      slot_in      = slot_ff;
      probe_in     = probe_ff;
      key_in       = key_ff;
      acc_in       = acc_ff;
      rem_in       = rem_ff;
      bit_in       = bit_ff;
      count_in     = count_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      mul_a        = '0;
      mul_b        = '0;
      wr_en        = 1'b0;
      wr_addr      = slot_ff;
      wr_entry     = '0;
      limit_in     = csr_write ? pwdata[COUNT_W-1:0] : limit_ff;

      unique case (state_ff)
         ST_CLEAR: begin
            // sweep every slot to invalid
            wr_en   = 1'b1;
            slot_in = slot_step;
            if (slot_ff == LAST_SLOT) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (start) begin
               key_in = req_data.value;
               if (req_data.is_null) begin
                  rsp_valid_in            = 1'b1;
                  rsp_in.pass             = 1'b1;
                  rsp_in.table_full_error = 1'b0;
               end else begin
                  state_in = ST_MUL0;
               end
            end
         end
         ST_MUL0: begin
            mul_a    = key_ff[31:0];
            mul_b    = HASH_MULT[31:0];
            state_in = ST_MUL1;
         end
         ST_MUL1: begin
            acc_in   = mul_ff;
            mul_a    = key_ff[63:32];
            mul_b    = HASH_MULT[31:0];
            state_in = ST_MUL2;
         end
         ST_MUL2: begin
            acc_in[63:32] = acc_ff[63:32] + mul_ff[31:0];
            mul_a         = key_ff[31:0];
            mul_b         = HASH_MULT[63:32];
            state_in      = ST_MUL3;
         end
         ST_MUL3: begin
            acc_in[63:32] = acc_ff[63:32] + mul_ff[31:0];
            state_in      = ST_MIX;
         end
         ST_MIX: begin
            probe_in = '0;
            if (IS_POW2) begin
               slot_in  = mixed[IDX_W-1:0];
               state_in = ST_PROBE;
            end else begin
               acc_in   = mixed;
               rem_in   = '0;
               bit_in   = '0;
               state_in = ST_MOD_EST;
            end
         end
         ST_MOD_EST: begin
            // estimate the digit quotient with the reciprocal
            mul_a    = mod_y;
            mul_b    = RECIP;
            state_in = ST_MOD_BACK;
         end
         ST_MOD_BACK: begin
            mul_a    = mul_ff[63:32];
            mul_b    = ENTRIES_32;
            state_in = ST_MOD_FIX;
         end
         ST_MOD_FIX: begin
            // the estimate is low by at most one, so one subtract settles it
            acc_in = {acc_ff[KEY_W-17:0], 16'd0};
            rem_in = rem_next;
            bit_in = bit_ff + 1'b1;
            if (bit_ff == DIGIT_LAST) begin
               slot_in  = rem_next;
               state_in = ST_PROBE;
            end else begin
               state_in = ST_MOD_EST;
            end
         end
         ST_PROBE: begin
            if (!rd_entry.valid) begin
               count_in = '0;
               state_in = ST_UPDATE;
            end else if (rd_entry.key == key_ff) begin
               count_in = rd_entry.count;
               state_in = ST_UPDATE;
            end else if (probe_ff == LAST_SLOT) begin
               // every slot holds another value
               rsp_valid_in            = 1'b1;
               rsp_in.pass             = 1'b0;
               rsp_in.table_full_error = 1'b1;
               state_in                = ST_IDLE;
            end else begin
               slot_in  = slot_step;
               probe_in = probe_ff + 1'b1;
            end
         end
         ST_UPDATE: begin
            wr_en                   = 1'b1;
            wr_entry.valid          = 1'b1;
            wr_entry.key            = key_ff;
            wr_entry.count          = count_next;
            rsp_valid_in            = 1'b1;
            rsp_in.pass             = (count_next <= limit_ff);
            rsp_in.table_full_error = 1'b0;
            state_in                = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      mul_in = {32'd0, mul_a} * {32'd0, mul_b};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         slot_ff      <= '0;
         limit_ff     <= LIMIT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         slot_ff      <= slot_in;
         limit_ff     <= limit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      probe_ff <= probe_in;
      key_ff   <= key_in;
      acc_ff   <= acc_in;
      mul_ff   <= mul_in;
      rem_ff   <= rem_in;
      bit_ff   <= bit_in;
      count_ff <= count_in;
      rsp_ff   <= rsp_in;
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
